@@ rtl/core/frsc_pkg.sv @@
// Shared types and constants for the framed packet receiver.
package frsc_pkg;

  localparam int BUF_DEPTH_DEF  = 32;
  localparam int ADDR_BYTES_DEF = 1;

  localparam int SLOT_W = 9;   // checksum slot: ADDR_BYTES + 4 + length
  localparam int CMP_W  = 10;  // room for slot + 1
  localparam int POS_W  = 5;
  localparam int IDX_W  = 5;

  localparam logic [7:0] START_BYTE_RST = 8'h68;
  localparam logic [7:0] END_BYTE_RST   = 8'h16;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [0:0] REG_START = 1'b0;
  localparam logic [0:0] REG_END   = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [IDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic             header_seen;
    logic             byte_stored;
    logic [POS_W-1:0] store_position;
    logic             checksum_seen;
    logic             checksum_bad;
    logic             frame_complete;
    logic             overflow;
    logic [7:0]       read_data;
  } out_t;

endpackage

@@ rtl/core/frsc_store.sv @@
// Frame byte store: one write port, one registered read port.
module frsc_store #(
  parameter int BUF_DEPTH = frsc_pkg::BUF_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic                        load,
  input  logic                        rd,
  input  logic [frsc_pkg::IDX_W-1:0]  rd_addr,
  output logic [7:0]                  rd_data
);

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int RW  = (AW > frsc_pkg::IDX_W) ? AW : frsc_pkg::IDX_W;
  localparam int RW1 = RW + 1;

  logic [7:0]     mem [BUF_DEPTH];
  logic [7:0]     mem_q;
  logic           hit_q;
  logic [RW1-1:0] idx_ext;
  logic           in_range;

  assign idx_ext  = RW1'(rd_addr);
  assign in_range = idx_ext < RW1'(BUF_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data is held with the result until the next request is taken
  always_ff @(posedge clk) begin
    if (load) begin
      mem_q <= mem[idx_ext[AW-1:0]];
      hit_q <= rd && in_range;
    end
  end

  assign rd_data = hit_q ? mem_q : 8'h00;

endmodule

@@ rtl/core/framed_packet_receiver_sum_check.sv @@
// Framed packet receiver: takes one request per clock (received byte, release or buffer read)
// and returns one result per request in the cycle after it is taken. The frame bytes after the
// start byte go into a single-port-write, registered-read buffer of BUF_DEPTH bytes; frame
// counters, the running 8-bit sum and the status flags live in registers updated in the
// cycle a request is taken. Input stalls only while a finished result waits on a stalled
// output. Start and end byte values are programmable over the APB port (0x0 and 0x4).
module framed_packet_receiver_sum_check #(
  parameter int BUF_DEPTH  = frsc_pkg::BUF_DEPTH_DEF,
  parameter int ADDR_BYTES = frsc_pkg::ADDR_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  frsc_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output frsc_pkg::out_t     out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW     = $clog2(BUF_DEPTH);
  localparam int CW     = $clog2(BUF_DEPTH + 1);
  localparam int SLOT_W = frsc_pkg::SLOT_W;
  localparam int CMP_W  = frsc_pkg::CMP_W;

  logic [7:0]        start_byte;
  logic [7:0]        end_byte;

  logic [CW-1:0]     byte_count, byte_count_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [SLOT_W-1:0] checksum_slot, checksum_slot_next;
  logic              hdr, hdr_next;
  logic              cs_seen, cs_seen_next;
  logic              cs_bad, cs_bad_next;
  logic              complete, complete_next;
  logic              ovf, ovf_next;

  logic              accept;
  logic              wr_en;
  logic [CMP_W-1:0]  at_cmp;
  logic [CMP_W-1:0]  slot_cmp;
  logic [7:0]        b;

  frsc_pkg::out_t    res;
  logic [7:0]        rd_data;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign b        = in_data.byte_value;
  assign at_cmp   = CMP_W'(byte_count);
  assign slot_cmp = CMP_W'(checksum_slot_next);

  // configuration
  assign pready = 1'b1;
  assign prdata = {24'h0, (paddr[2] == frsc_pkg::REG_END) ? end_byte : start_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= frsc_pkg::START_BYTE_RST;
      end_byte   <= frsc_pkg::END_BYTE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == frsc_pkg::REG_END) begin
        end_byte <= pwdata[7:0];
      end else begin
        start_byte <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    byte_count_next    = byte_count;
    running_sum_next   = running_sum;
    checksum_slot_next = checksum_slot;
    hdr_next           = hdr;
    cs_seen_next       = cs_seen;
    cs_bad_next        = cs_bad;
    complete_next      = complete;
    ovf_next           = ovf;
    wr_en              = 1'b0;
    if (accept) begin
      unique case (in_data.kind)
        frsc_pkg::KIND_BYTE: begin
          if (!complete) begin
            if (!hdr) begin
              if (b == start_byte) begin
                hdr_next         = 1'b1;
                running_sum_next = b;
              end
            end else if (byte_count >= CW'(BUF_DEPTH)) begin
              ovf_next = 1'b1;
            end else begin
              wr_en = 1'b1;
              if (at_cmp == CMP_W'(ADDR_BYTES + 3)) begin
                checksum_slot_next = SLOT_W'(ADDR_BYTES + 4) + SLOT_W'(b);
              end
              if (at_cmp > CMP_W'(ADDR_BYTES + 2)) begin
                if (at_cmp == slot_cmp) begin
                  cs_bad_next  = (running_sum != b);
                  cs_seen_next = 1'b1;
                end
                if ((at_cmp == slot_cmp + CMP_W'(1)) && (b == end_byte)) begin
                  complete_next = 1'b1;
                end
              end
              if (!cs_seen_next) begin
                running_sum_next = running_sum + b;
              end
              byte_count_next = byte_count + CW'(1);
            end
          end
        end
        frsc_pkg::KIND_RELEASE: begin
          byte_count_next    = '0;
          running_sum_next   = '0;
          checksum_slot_next = '0;
          hdr_next           = 1'b0;
          cs_seen_next       = 1'b0;
          cs_bad_next        = 1'b0;
          complete_next      = 1'b0;
          ovf_next           = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_sum   <= '0;
      checksum_slot <= '0;
      hdr           <= 1'b0;
      cs_seen       <= 1'b0;
      cs_bad        <= 1'b0;
      complete      <= 1'b0;
      ovf           <= 1'b0;
    end else begin
      byte_count    <= byte_count_next;
      running_sum   <= running_sum_next;
      checksum_slot <= checksum_slot_next;
      hdr           <= hdr_next;
      cs_seen       <= cs_seen_next;
      cs_bad        <= cs_bad_next;
      complete      <= complete_next;
      ovf           <= ovf_next;
    end
  end

  // result register; the buffer's read register moves with it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.header_seen    <= hdr_next;
      res.byte_stored    <= wr_en;
      res.store_position <= wr_en ? frsc_pkg::POS_W'(byte_count) : '0;
      res.checksum_seen  <= cs_seen_next;
      res.checksum_bad   <= cs_bad_next;
      res.frame_complete <= complete_next;
      res.overflow       <= ovf_next;
      res.read_data      <= 8'h00;
    end
  end

  frsc_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (b),
    .load    (accept),
    .rd      (in_data.kind == frsc_pkg::KIND_READ),
    .rd_addr (in_data.read_index),
    .rd_data (rd_data)
  );

  always_comb begin
    out_data           = res;
    out_data.read_data = rd_data;
  end

endmodule

@@ rtl/core/frsc_checker.sv @@
// Port-level checker for the framed packet receiver, bound to the top level.
module frsc_port_checks (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input frsc_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input frsc_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_stored |-> out_data.store_position == '0)
    else $error("store position set without a stored byte");

  a_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_complete |->
      out_data.checksum_seen && out_data.header_seen)
    else $error("frame complete before checksum");

  a_bad_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.checksum_bad |-> out_data.checksum_seen)
    else $error("checksum bad without checksum seen");

  a_release: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.kind == frsc_pkg::KIND_RELEASE |=>
      out_valid && !out_data.header_seen && !out_data.overflow &&
      !out_data.frame_complete)
    else $error("release did not clear the frame");

endmodule

bind framed_packet_receiver_sum_check frsc_port_checks u_port_checks (.*);
